### hw/rtl/bpe_pkg.sv
// ----------------------------------------------------------------------------
// bpe_pkg
// Kind codes, tag numbers, limits and stage records shared by the primitive
// encoder.
// ----------------------------------------------------------------------------
package bpe_pkg;

  typedef enum logic [3:0] {
    FN_NULL     = 4'd0,
    FN_BOOL     = 4'd1,
    FN_UNS      = 4'd2,
    FN_SGN      = 4'd3,
    FN_REAL     = 4'd4,
    FN_DBL      = 4'd5,
    FN_DATE     = 4'd6,
    FN_TIME     = 4'd7,
    FN_OID      = 4'd8,
    FN_ENUM     = 4'd9,
    FN_CTX_UNS  = 4'd10,
    FN_CTX_SGN  = 4'd11,
    FN_CTX_BOOL = 4'd12,
    FN_OPEN     = 4'd13,
    FN_CLOSE    = 4'd14
  } func_t;

  // application tag numbers
  localparam logic [7:0] TAG_NULL   = 8'd0;
  localparam logic [7:0] TAG_BOOL   = 8'd1;
  localparam logic [7:0] TAG_UNS    = 8'd2;
  localparam logic [7:0] TAG_SGN    = 8'd3;
  localparam logic [7:0] TAG_REAL   = 8'd4;
  localparam logic [7:0] TAG_DOUBLE = 8'd5;
  localparam logic [7:0] TAG_ENUM   = 8'd9;
  localparam logic [7:0] TAG_DATE   = 8'd10;
  localparam logic [7:0] TAG_TIME   = 8'd11;
  localparam logic [7:0] TAG_OID    = 8'd12;

  localparam logic [7:0] TAG_EXT_MIN  = 8'd15;
  localparam logic [7:0] TAG_RESERVED = 8'd255;
  localparam logic [3:0] TAG_EXT_MARK = 4'hF;

  localparam logic [2:0] LVT_EXT   = 3'd5;
  localparam logic [2:0] LVT_OPEN  = 3'd6;
  localparam logic [2:0] LVT_CLOSE = 3'd7;
  localparam logic [3:0] LEN_EXT_MIN = 4'd5;

  localparam logic [30:0] REAL_INF = 31'h7F80_0000;
  localparam logic [62:0] DBL_INF  = 63'h7FF0_0000_0000_0000;

  localparam logic [15:0] YEAR_ANY  = 16'hFFFF;
  localparam logic [15:0] YEAR_MIN  = 16'd1900;
  localparam logic [15:0] YEAR_MAX  = 16'd2154;
  localparam logic [7:0]  FIELD_ANY = 8'hFF;
  localparam logic [7:0]  MONTH_MAX = 8'd14;
  localparam logic [7:0]  DAY_MAX   = 8'd34;
  localparam logic [7:0]  WDAY_MAX  = 8'd7;
  localparam logic [15:0] HOUR_MAX  = 16'd23;
  localparam logic [7:0]  MIN_MAX   = 8'd59;
  localparam logic [7:0]  HUND_MAX  = 8'd99;
  localparam logic [15:0] OTYPE_MAX = 16'd1023;

  localparam int BUF_BYTES = 10;

  // decoded value, before the header is built
  typedef struct packed {
    logic        ok;
    logic [7:0]  tag;
    logic        ctx;
    logic        raw;
    logic [2:0]  lvt;
    logic [3:0]  clen;
    logic [63:0] content;   // content octets, left aligned
    logic [7:0]  room;
  } dec_t;

  // framed octet string, ready to shift out
  typedef struct packed {
    logic                   err;
    logic [3:0]             count;
    logic [BUF_BYTES*8-1:0] octets;  // first octet in the top byte
  } frm_t;

endpackage

### hw/rtl/bpe_if.sv
// ----------------------------------------------------------------------------
// bpe_if
// Valid/ready channels of the primitive encoder: value in, octets out.
// ----------------------------------------------------------------------------
interface bpe_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [7:0]  ctx_tag;
  logic [63:0] value;
  logic [15:0] part_one;
  logic [7:0]  part_two;
  logic [7:0]  part_three;
  logic [7:0]  part_four;
  logic [7:0]  room;

  modport source (
    output valid, func, ctx_tag, value, part_one, part_two, part_three,
           part_four, room,
    input  ready
  );
  modport sink (
    input  valid, func, ctx_tag, value, part_one, part_two, part_three,
           part_four, room,
    output ready
  );
endinterface

interface bpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

### hw/rtl/bpe_decode.sv
// ----------------------------------------------------------------------------
// bpe_decode
// First stage: range checks, tag selection and content octets per kind.
// ----------------------------------------------------------------------------
module bpe_decode (
  input  logic            clk,
  input  logic            rst_n,
  bpe_in_if.sink          in_ch,
  output logic            dec_valid,
  input  logic            dec_ready,
  output bpe_pkg::dec_t   dec_data
);

  logic           valid_r;
  bpe_pkg::dec_t  data_r;
  bpe_pkg::dec_t  data_nxt;

  bpe_pkg::func_t fn;
  logic [31:0]    lo;
  logic [31:0]    mag;
  logic [31:0]    msrc;
  logic           sgn;
  logic [3:0]     nmin;
  logic [63:0]    int_content;
  logic [15:0]    yoff;
  logic [7:0]     ybyte;
  logic           date_ok;
  logic           time_ok;
  logic           nonzero;

  assign in_ch.ready = !valid_r || dec_ready;
  assign dec_valid   = valid_r;
  assign dec_data    = data_r;

  always_comb begin
    fn      = bpe_pkg::func_t'(in_ch.func);
    lo      = in_ch.value[31:0];
    nonzero = (in_ch.value != 64'd0);
    sgn     = (fn == bpe_pkg::FN_SGN) || (fn == bpe_pkg::FN_CTX_SGN);
    mag     = lo[31] ? ~lo : lo;
    // signed values keep one spare bit for the sign
    msrc    = sgn ? {mag[30:0], 1'b0} : lo;
    if (msrc[31:24] != 8'd0) begin
      nmin = 4'd4;
    end else if (msrc[23:16] != 8'd0) begin
      nmin = 4'd3;
    end else if (msrc[15:8] != 8'd0) begin
      nmin = 4'd2;
    end else begin
      nmin = 4'd1;
    end
    case (nmin)
      4'd1:    int_content = {lo[7:0], 56'd0};
      4'd2:    int_content = {lo[15:0], 48'd0};
      4'd3:    int_content = {lo[23:0], 40'd0};
      default: int_content = {lo, 32'd0};
    endcase

    yoff  = in_ch.part_one - bpe_pkg::YEAR_MIN;
    ybyte = (in_ch.part_one == bpe_pkg::YEAR_ANY) ? bpe_pkg::FIELD_ANY : yoff[7:0];
    date_ok = ((in_ch.part_one == bpe_pkg::YEAR_ANY) ||
               (in_ch.part_one >= bpe_pkg::YEAR_MIN &&
                in_ch.part_one <= bpe_pkg::YEAR_MAX)) &&
              ((in_ch.part_two >= 8'd1 && in_ch.part_two <= bpe_pkg::MONTH_MAX) ||
               in_ch.part_two == bpe_pkg::FIELD_ANY) &&
              ((in_ch.part_three >= 8'd1 && in_ch.part_three <= bpe_pkg::DAY_MAX) ||
               in_ch.part_three == bpe_pkg::FIELD_ANY) &&
              ((in_ch.part_four >= 8'd1 && in_ch.part_four <= bpe_pkg::WDAY_MAX) ||
               in_ch.part_four == bpe_pkg::FIELD_ANY);
    time_ok = (in_ch.part_one <= bpe_pkg::HOUR_MAX ||
               in_ch.part_one == {8'd0, bpe_pkg::FIELD_ANY}) &&
              (in_ch.part_two <= bpe_pkg::MIN_MAX ||
               in_ch.part_two == bpe_pkg::FIELD_ANY) &&
              (in_ch.part_three <= bpe_pkg::MIN_MAX ||
               in_ch.part_three == bpe_pkg::FIELD_ANY) &&
              (in_ch.part_four <= bpe_pkg::HUND_MAX ||
               in_ch.part_four == bpe_pkg::FIELD_ANY);
  end

  always_comb begin
    data_nxt      = '0;
    data_nxt.ok   = 1'b1;
    data_nxt.room = in_ch.room;
    unique case (fn) inside
      bpe_pkg::FN_NULL: begin
        data_nxt.tag = bpe_pkg::TAG_NULL;
        data_nxt.raw = 1'b1;
      end
      bpe_pkg::FN_BOOL: begin
        data_nxt.tag = bpe_pkg::TAG_BOOL;
        data_nxt.raw = 1'b1;
        data_nxt.lvt = {2'd0, nonzero};
      end
      bpe_pkg::FN_UNS, bpe_pkg::FN_SGN, bpe_pkg::FN_ENUM,
      bpe_pkg::FN_CTX_UNS, bpe_pkg::FN_CTX_SGN: begin
        if (fn == bpe_pkg::FN_UNS) begin
          data_nxt.tag = bpe_pkg::TAG_UNS;
        end else if (fn == bpe_pkg::FN_SGN) begin
          data_nxt.tag = bpe_pkg::TAG_SGN;
        end else if (fn == bpe_pkg::FN_ENUM) begin
          data_nxt.tag = bpe_pkg::TAG_ENUM;
        end else begin
          data_nxt.tag = in_ch.ctx_tag;
        end
        data_nxt.ctx     = (fn == bpe_pkg::FN_CTX_UNS) || (fn == bpe_pkg::FN_CTX_SGN);
        data_nxt.clen    = nmin;
        data_nxt.content = int_content;
      end
      bpe_pkg::FN_CTX_BOOL: begin
        data_nxt.tag     = in_ch.ctx_tag;
        data_nxt.ctx     = 1'b1;
        data_nxt.clen    = 4'd1;
        data_nxt.content = {7'd0, nonzero, 56'd0};
      end
      bpe_pkg::FN_REAL: begin
        data_nxt.tag     = bpe_pkg::TAG_REAL;
        data_nxt.ok      = !(lo[30:0] > bpe_pkg::REAL_INF);
        data_nxt.clen    = 4'd4;
        data_nxt.content = {lo, 32'd0};
      end
      bpe_pkg::FN_DBL: begin
        data_nxt.tag     = bpe_pkg::TAG_DOUBLE;
        data_nxt.ok      = !(in_ch.value[62:0] > bpe_pkg::DBL_INF);
        data_nxt.clen    = 4'd8;
        data_nxt.content = in_ch.value;
      end
      bpe_pkg::FN_DATE: begin
        data_nxt.tag     = bpe_pkg::TAG_DATE;
        data_nxt.ok      = date_ok;
        data_nxt.clen    = 4'd4;
        data_nxt.content = {ybyte, in_ch.part_two, in_ch.part_three, in_ch.part_four,
                            32'd0};
      end
      bpe_pkg::FN_TIME: begin
        data_nxt.tag     = bpe_pkg::TAG_TIME;
        data_nxt.ok      = time_ok;
        data_nxt.clen    = 4'd4;
        data_nxt.content = {in_ch.part_one[7:0], in_ch.part_two, in_ch.part_three,
                            in_ch.part_four, 32'd0};
      end
      bpe_pkg::FN_OID: begin
        data_nxt.tag     = bpe_pkg::TAG_OID;
        data_nxt.ok      = (in_ch.part_one <= bpe_pkg::OTYPE_MAX) &&
                           (in_ch.value[63:22] == 42'd0);
        data_nxt.clen    = 4'd4;
        data_nxt.content = {in_ch.part_one[9:0], lo[21:0], 32'd0};
      end
      bpe_pkg::FN_OPEN, bpe_pkg::FN_CLOSE: begin
        data_nxt.tag = in_ch.ctx_tag;
        data_nxt.ctx = 1'b1;
        data_nxt.raw = 1'b1;
        data_nxt.lvt = (fn == bpe_pkg::FN_OPEN) ? bpe_pkg::LVT_OPEN : bpe_pkg::LVT_CLOSE;
      end
      default: begin
        data_nxt.ok = 1'b0;
      end
    endcase
    // context tag 255 is reserved
    if (data_nxt.ctx && data_nxt.tag == bpe_pkg::TAG_RESERVED) begin
      data_nxt.ok = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### hw/rtl/bpe_frame.sv
// ----------------------------------------------------------------------------
// bpe_frame
// Second stage: tag header with extended tag and length octets, room check,
// and the complete octet string for the output shifter.
// ----------------------------------------------------------------------------
module bpe_frame (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           dec_valid,
  output logic           dec_ready,
  input  bpe_pkg::dec_t  dec_data,
  output logic           frm_valid,
  input  logic           frm_ready,
  output bpe_pkg::frm_t  frm_data
);

  localparam int BufW = bpe_pkg::BUF_BYTES * 8;

  logic           valid_r;
  bpe_pkg::frm_t  data_r;
  bpe_pkg::frm_t  data_nxt;

  logic            ext_tag;
  logic            ext_len;
  logic [2:0]      lvt_field;
  logic [7:0]      byte0;
  logic [23:0]     hdr;
  logic [1:0]      hlen;
  logic [3:0]      total;
  logic [BufW-1:0] body;
  logic            fits;

  assign dec_ready = !valid_r || frm_ready;
  assign frm_valid = valid_r;
  assign frm_data  = data_r;

  always_comb begin
    ext_tag   = (dec_data.tag >= bpe_pkg::TAG_EXT_MIN);
    ext_len   = !dec_data.raw && (dec_data.clen >= bpe_pkg::LEN_EXT_MIN);
    lvt_field = dec_data.raw ? dec_data.lvt :
                ext_len      ? bpe_pkg::LVT_EXT : dec_data.clen[2:0];
    byte0     = {(ext_tag ? bpe_pkg::TAG_EXT_MARK : dec_data.tag[3:0]),
                 dec_data.ctx, lvt_field};
    case ({ext_tag, ext_len})
      2'b10:   hdr = {byte0, dec_data.tag, 8'd0};
      2'b01:   hdr = {byte0, 4'd0, dec_data.clen, 8'd0};
      2'b11:   hdr = {byte0, dec_data.tag, 4'd0, dec_data.clen};
      default: hdr = {byte0, 16'd0};
    endcase
    hlen  = 2'd1 + {1'b0, ext_tag} + {1'b0, ext_len};
    total = {2'd0, hlen} + dec_data.clen;
    // place the content octets right behind the header
    body  = {dec_data.content, 16'd0} >> {hlen, 3'b000};
    fits  = ({4'd0, total} <= dec_data.room);

    data_nxt.err = !(dec_data.ok && fits);
    if (data_nxt.err) begin
      data_nxt.count  = 4'd1;
      data_nxt.octets = '0;
    end else begin
      data_nxt.count  = total;
      data_nxt.octets = {hdr, {(BufW - 24){1'b0}}} | body;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (dec_ready) begin
      valid_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_ready && dec_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

### hw/rtl/bpe_serial.sv
// ----------------------------------------------------------------------------
// bpe_serial
// Output stage: shift register that sends one octet per transaction and
// takes the next framed value as the final octet leaves.
// ----------------------------------------------------------------------------
module bpe_serial (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           frm_valid,
  output logic           frm_ready,
  input  bpe_pkg::frm_t  frm_data,
  bpe_out_if.source      out_ch
);

  localparam int BufW = bpe_pkg::BUF_BYTES * 8;

  logic            busy_r;
  logic [BufW-1:0] buf_r;
  logic [3:0]      rem_r;
  logic            err_r;

  logic            final_oct;
  logic            pop;

  assign final_oct = (rem_r == 4'd1);
  assign pop       = busy_r && out_ch.ready;
  assign frm_ready = !busy_r || (out_ch.ready && final_oct);

  assign out_ch.valid    = busy_r;
  assign out_ch.out_byte = buf_r[BufW-1 -: 8];
  assign out_ch.last     = final_oct;
  assign out_ch.error    = err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (frm_ready) begin
      busy_r <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (frm_ready && frm_valid) begin
      buf_r <= frm_data.octets;
      rem_r <= frm_data.count;
      err_r <= frm_data.err;
    end else if (pop && !final_oct) begin
      // advance to the next octet
      buf_r <= {buf_r[BufW-9:0], 8'd0};
      rem_r <= rem_r - 4'd1;
    end
  end

endmodule

### hw/rtl/bacnet_primitive_encoder.sv
// ----------------------------------------------------------------------------
// bacnet_primitive_encoder
// Encodes one primitive value per input transaction into its tagged octet
// string, one octet per output transaction, most significant first.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                         | flow
//   in_ch   | in  | func ctx_tag value part_one..part_four room      | valid/ready
//   out_ch  | out | out_byte last error                              | valid/ready
//
// An input transaction passes the decode and framing registers and then
// leaves as 1 to 10 output transactions, one octet per cycle while out_ch is
// ready; a rejected value leaves as a single error octet. The output shift
// register sets the rate, with the next value loaded as the final octet goes.
// Synchronous active-low reset empties all three stages.
// A stall on out_ch holds each stage; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module bacnet_primitive_encoder (
  input  logic       clk,
  input  logic       rst_n,
  bpe_in_if.sink     in_ch,
  bpe_out_if.source  out_ch
);

  logic           dec_valid;
  logic           dec_ready;
  bpe_pkg::dec_t  dec_data;
  logic           frm_valid;
  logic           frm_ready;
  bpe_pkg::frm_t  frm_data;

  bpe_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data)
  );

  bpe_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec_data  (dec_data),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data)
  );

  bpe_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .frm_valid (frm_valid),
    .frm_ready (frm_ready),
    .frm_data  (frm_data),
    .out_ch    (out_ch)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the primitive value encoder. A queue of directed and
// random values feeds a valid/ready driver. Each accepted value is encoded by
// a local model into its expected octets. A monitor compares every output
// octet, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int RESET_CYCLES = 4;
  localparam int DRAIN_CYCLES = 20;
  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 85;
  localparam int QUIET_TAIL   = 15;

  typedef struct {
    bpe_pkg::func_t func;
    logic [7:0]     ctx_tag;
    logic [63:0]    value;
    logic [15:0]    part_one;
    logic [7:0]     part_two;
    logic [7:0]     part_three;
    logic [7:0]     part_four;
    logic [7:0]     room;
  } prim_t;

  typedef struct {
    logic [7:0] octet;
    logic       last;
    logic       err;
  } octet_t;

  logic clk;
  logic rst_n;

  bpe_in_if  in_if ();
  bpe_out_if out_if ();

  bacnet_primitive_encoder u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  prim_t  stim_q[$];
  octet_t octet_q[$];
  prim_t  cur_prim;
  int     n_items;
  int     sent_cnt;
  int     fail_cnt;
  int     quiet_cycles;
  int     in_gap;
  int     out_gap;
  logic   in_took;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fewest octets that hold v; a signed value keeps room for its sign bit
  function automatic int min_octets(logic [31:0] v, bit sgn);
    logic [31:0] m;
    int n;
    m = sgn ? ((v[31] ? ~v : v) << 1) : v;
    n = 1;
    while (n < 4 && (m >> (8 * n)) != 0) n++;
    return n;
  endfunction

  function automatic bit field_ok(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
    return (v >= lo && v <= hi) || v == bpe_pkg::FIELD_ANY;
  endfunction

  // encode one value into the octets the block must emit
  function automatic void encode_octets(prim_t p);
    logic [7:0]  body[$];
    logic [7:0]  frame[$];
    logic [31:0] lo;
    logic [31:0] word;
    logic [7:0]  tag;
    logic [7:0]  hdr;
    logic [3:0]  lvt;
    bit          ctx;
    bit          raw;
    bit          ok;
    int          n;
    int          i;
    octet_t      o;
    lo  = p.value[31:0];
    tag = bpe_pkg::TAG_NULL;
    lvt = '0;
    ctx = 1'b0;
    raw = 1'b0;
    ok  = 1'b1;
    case (p.func)
      bpe_pkg::FN_NULL: begin
        raw = 1'b1;
      end
      bpe_pkg::FN_BOOL: begin
        tag = bpe_pkg::TAG_BOOL;
        raw = 1'b1;
        lvt = (p.value != 0) ? 4'd1 : 4'd0;
      end
      bpe_pkg::FN_UNS, bpe_pkg::FN_ENUM, bpe_pkg::FN_CTX_UNS, bpe_pkg::FN_SGN,
      bpe_pkg::FN_CTX_SGN: begin
        case (p.func)
          bpe_pkg::FN_UNS:  tag = bpe_pkg::TAG_UNS;
          bpe_pkg::FN_ENUM: tag = bpe_pkg::TAG_ENUM;
          bpe_pkg::FN_SGN:  tag = bpe_pkg::TAG_SGN;
          default:          tag = p.ctx_tag;
        endcase
        ctx = (p.func == bpe_pkg::FN_CTX_UNS) || (p.func == bpe_pkg::FN_CTX_SGN);
        n = min_octets(lo, (p.func == bpe_pkg::FN_SGN) || (p.func == bpe_pkg::FN_CTX_SGN));
        for (i = n - 1; i >= 0; i--) body.push_back(lo[8*i +: 8]);
      end
      bpe_pkg::FN_CTX_BOOL: begin
        tag = p.ctx_tag;
        ctx = 1'b1;
        body.push_back((p.value != 0) ? 8'd1 : 8'd0);
      end
      bpe_pkg::FN_REAL: begin
        tag = bpe_pkg::TAG_REAL;
        if (lo[30:0] > bpe_pkg::REAL_INF) ok = 1'b0;
        for (i = 3; i >= 0; i--) body.push_back(lo[8*i +: 8]);
      end
      bpe_pkg::FN_DBL: begin
        tag = bpe_pkg::TAG_DOUBLE;
        if (p.value[62:0] > bpe_pkg::DBL_INF) ok = 1'b0;
        for (i = 7; i >= 0; i--) body.push_back(p.value[8*i +: 8]);
      end
      bpe_pkg::FN_DATE: begin
        tag = bpe_pkg::TAG_DATE;
        if (p.part_one == bpe_pkg::YEAR_ANY) body.push_back(bpe_pkg::FIELD_ANY);
        else if (p.part_one >= bpe_pkg::YEAR_MIN && p.part_one <= bpe_pkg::YEAR_MAX)
          body.push_back(8'(p.part_one - bpe_pkg::YEAR_MIN));
        else begin
          ok = 1'b0;
          body.push_back(8'h00);
        end
        if (!field_ok(p.part_two, 8'd1, bpe_pkg::MONTH_MAX)) ok = 1'b0;
        if (!field_ok(p.part_three, 8'd1, bpe_pkg::DAY_MAX)) ok = 1'b0;
        if (!field_ok(p.part_four, 8'd1, bpe_pkg::WDAY_MAX)) ok = 1'b0;
        body.push_back(p.part_two);
        body.push_back(p.part_three);
        body.push_back(p.part_four);
      end
      bpe_pkg::FN_TIME: begin
        tag = bpe_pkg::TAG_TIME;
        if (!(p.part_one <= bpe_pkg::HOUR_MAX ||
              p.part_one == 16'(bpe_pkg::FIELD_ANY))) ok = 1'b0;
        if (!field_ok(p.part_two, 8'd0, bpe_pkg::MIN_MAX)) ok = 1'b0;
        if (!field_ok(p.part_three, 8'd0, bpe_pkg::MIN_MAX)) ok = 1'b0;
        if (!field_ok(p.part_four, 8'd0, bpe_pkg::HUND_MAX)) ok = 1'b0;
        body.push_back(p.part_one[7:0]);
        body.push_back(p.part_two);
        body.push_back(p.part_three);
        body.push_back(p.part_four);
      end
      bpe_pkg::FN_OID: begin
        tag = bpe_pkg::TAG_OID;
        if (p.part_one > bpe_pkg::OTYPE_MAX || p.value > 64'h3F_FFFF) ok = 1'b0;
        word = {p.part_one[9:0], lo[21:0]};
        for (i = 3; i >= 0; i--) body.push_back(word[8*i +: 8]);
      end
      bpe_pkg::FN_OPEN, bpe_pkg::FN_CLOSE: begin
        tag = p.ctx_tag;
        ctx = 1'b1;
        raw = 1'b1;
        lvt = (p.func == bpe_pkg::FN_OPEN) ? 4'(bpe_pkg::LVT_OPEN)
                                           : 4'(bpe_pkg::LVT_CLOSE);
      end
      default: ok = 1'b0;
    endcase
    if (ctx && tag == bpe_pkg::TAG_RESERVED) ok = 1'b0;

    if (ok) begin
      if (!raw) lvt = 4'(body.size());
      hdr = (tag < bpe_pkg::TAG_EXT_MIN) ? {tag[3:0], 4'h0} : {bpe_pkg::TAG_EXT_MARK, 4'h0};
      hdr[3] = ctx;
      hdr[2:0] = (raw || lvt < bpe_pkg::LEN_EXT_MIN) ? lvt[2:0] : bpe_pkg::LVT_EXT;
      frame.push_back(hdr);
      if (tag >= bpe_pkg::TAG_EXT_MIN) frame.push_back(tag);
      if (!raw && lvt >= bpe_pkg::LEN_EXT_MIN) frame.push_back(8'(lvt));
      foreach (body[k]) frame.push_back(body[k]);
      if (frame.size() > p.room) ok = 1'b0;
    end

    if (!ok) begin
      o.octet = 8'h00;
      o.last  = 1'b1;
      o.err   = 1'b1;
      octet_q.push_back(o);
    end else begin
      foreach (frame[k]) begin
        o.octet = frame[k];
        o.last  = (k == frame.size() - 1);
        o.err   = 1'b0;
        octet_q.push_back(o);
      end
    end
  endfunction

  task automatic add_prim(bpe_pkg::func_t f, logic [7:0] t, logic [63:0] v,
                          logic [15:0] p1, logic [7:0] p2, logic [7:0] p3,
                          logic [7:0] p4, logic [7:0] room);
    prim_t p;
    p.func       = f;
    p.ctx_tag    = t;
    p.value      = v;
    p.part_one   = p1;
    p.part_two   = p2;
    p.part_three = p3;
    p.part_four  = p4;
    p.room       = room;
    stim_q.push_back(p);
  endtask

  function automatic logic [7:0] pick_field(logic [7:0] lo, logic [7:0] hi);
    if ($urandom_range(0, 7) == 0) return bpe_pkg::FIELD_ANY;
    return 8'($urandom_range(lo, hi));
  endfunction

  // mostly well-formed values with random content, the rest malformed
  function automatic prim_t rand_prim();
    prim_t       p;
    logic [31:0] lo;
    int          pick;
    p.func    = bpe_pkg::func_t'($urandom_range(bpe_pkg::FN_NULL, bpe_pkg::FN_CLOSE));
    p.ctx_tag = $urandom_range(0, 1) ? 8'($urandom_range(0, 14)) : 8'($urandom);
    if ($urandom_range(0, 15) == 0) p.ctx_tag = bpe_pkg::TAG_RESERVED;
    lo = $urandom >> (8 * $urandom_range(0, 3));
    if ($urandom_range(0, 1)) lo = ~lo;
    p.value      = {32'($urandom), lo};
    p.part_one   = 16'($urandom);
    p.part_two   = 8'($urandom);
    p.part_three = 8'($urandom);
    p.part_four  = 8'($urandom);
    p.room = ($urandom_range(0, 7) != 0) ? 8'($urandom_range(10, 255))
                                         : 8'($urandom_range(0, 11));
    pick = $urandom_range(0, 3);
    case (p.func)
      bpe_pkg::FN_BOOL, bpe_pkg::FN_CTX_BOOL: if (pick == 0) p.value = '0;
      bpe_pkg::FN_REAL: if (pick == 0) begin
        p.value[30:23] = '1;
        if ($urandom_range(0, 1)) p.value[22:0] = '0;
      end
      bpe_pkg::FN_DBL: if (pick == 0) begin
        p.value[62:52] = '1;
        if ($urandom_range(0, 1)) p.value[51:0] = '0;
      end
      bpe_pkg::FN_DATE: if (pick != 0) begin
        p.part_one = ($urandom_range(0, 7) == 0) ?
                     bpe_pkg::YEAR_ANY :
                     16'($urandom_range(bpe_pkg::YEAR_MIN, bpe_pkg::YEAR_MAX));
        p.part_two   = pick_field(8'd1, bpe_pkg::MONTH_MAX);
        p.part_three = pick_field(8'd1, bpe_pkg::DAY_MAX);
        p.part_four  = pick_field(8'd1, bpe_pkg::WDAY_MAX);
      end
      bpe_pkg::FN_TIME: if (pick != 0) begin
        p.part_one   = 16'(pick_field(8'd0, 8'(bpe_pkg::HOUR_MAX)));
        p.part_two   = pick_field(8'd0, bpe_pkg::MIN_MAX);
        p.part_three = pick_field(8'd0, bpe_pkg::MIN_MAX);
        p.part_four  = pick_field(8'd0, bpe_pkg::HUND_MAX);
      end
      bpe_pkg::FN_OID: if (pick != 0) begin
        p.part_one = 16'($urandom_range(0, bpe_pkg::OTYPE_MAX));
        p.value    = 64'($urandom_range(0, 32'h3F_FFFF));
      end else if ($urandom_range(0, 1)) begin
        p.value = 64'($urandom_range(0, 32'h3F_FFFF));
      end
      default: ;
    endcase
    return p;
  endfunction

  // idle in phases, and never near the end of the run
  function automatic bit may_idle();
    return stim_q.size() > QUIET_TAIL && (sent_cnt % 32) < 24 &&
           $urandom_range(0, 4) == 0;
  endfunction

  // input driver: hold a value until its transaction completes
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_if.valid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (may_idle()) begin
        in_gap = $urandom_range(0, 5);
        in_if.valid <= 1'b0;
      end else begin
        cur_prim = stim_q.pop_front();
        in_if.func       <= cur_prim.func;
        in_if.ctx_tag    <= cur_prim.ctx_tag;
        in_if.value      <= cur_prim.value;
        in_if.part_one   <= cur_prim.part_one;
        in_if.part_two   <= cur_prim.part_two;
        in_if.part_three <= cur_prim.part_three;
        in_if.part_four  <= cur_prim.part_four;
        in_if.room       <= cur_prim.room;
        in_if.valid      <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_if.ready <= 1'b0;
    end else if (may_idle()) begin
      out_gap = $urandom_range(0, 5);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // monitor, scoreboard and watchdog
  always @(posedge clk) begin : check_blk
    octet_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_took <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready) begin
        encode_octets(cur_prim);
        sent_cnt++;
      end
      if (out_if.valid && out_if.ready) begin
        if (octet_q.size() == 0) begin
          $error("out_byte: expected none, got %02h", out_if.out_byte);
          fail_cnt++;
        end else begin
          want = octet_q.pop_front();
          if (out_if.out_byte !== want.octet) begin
            $error("out_byte: expected %02h, got %02h", want.octet, out_if.out_byte);
            fail_cnt++;
          end
          if (out_if.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_if.last);
            fail_cnt++;
          end
          if (out_if.error !== want.err) begin
            $error("error: expected %0b, got %0b", want.err, out_if.error);
            fail_cnt++;
          end
        end
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  initial begin
    int r;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.func       = bpe_pkg::FN_NULL;
    in_if.ctx_tag    = '0;
    in_if.value      = '0;
    in_if.part_one   = '0;
    in_if.part_two   = '0;
    in_if.part_three = '0;
    in_if.part_four  = '0;
    in_if.room       = '0;
    out_if.ready     = 1'b0;
    in_took          = 1'b0;
    sent_cnt         = 0;
    fail_cnt         = 0;
    quiet_cycles     = 0;
    in_gap           = 0;
    out_gap          = 0;

    add_prim(bpe_pkg::FN_NULL, 8'd0, 64'h0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd1);
    add_prim(bpe_pkg::FN_NULL, 8'd0, 64'h0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    add_prim(bpe_pkg::FN_BOOL, 8'd0, 64'h8000_0000_0000_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_UNS, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_SGN, 8'd0, 64'h0000_0000_FFFF_FFFF, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_SGN, 8'd0, 64'h0000_0000_8000_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_ENUM, 8'd0, 64'h0001_2345, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_REAL, 8'd0, 64'h7F80_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_REAL, 8'd0, 64'h7F80_0001, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_DBL, 8'd0, 64'h3FF0_0000_0000_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd10);
    add_prim(bpe_pkg::FN_DBL, 8'd0, 64'h3FF0_0000_0000_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd9);
    add_prim(bpe_pkg::FN_DBL, 8'd0, 64'hFFF8_0000_0000_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_DATE, 8'd0, 64'h0, bpe_pkg::YEAR_MIN, 8'd1, 8'd1, 8'd1, 8'd255);
    add_prim(bpe_pkg::FN_DATE, 8'd0, 64'h0, bpe_pkg::YEAR_MAX, 8'd14, 8'd34, 8'd7, 8'd255);
    add_prim(bpe_pkg::FN_DATE, 8'd0, 64'h0, bpe_pkg::YEAR_ANY, 8'd255, 8'd255, 8'd255, 8'd255);
    add_prim(bpe_pkg::FN_DATE, 8'd0, 64'h0, 16'd1899, 8'd1, 8'd1, 8'd1, 8'd255);
    add_prim(bpe_pkg::FN_TIME, 8'd0, 64'h0, 16'd23, 8'd59, 8'd59, 8'd99, 8'd255);
    add_prim(bpe_pkg::FN_TIME, 8'd0, 64'h0, 16'h0100, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_OID, 8'd0, 64'h3F_FFFF, 16'd1023, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_OID, 8'd0, 64'h40_0000, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_CTX_UNS, 8'd15, 64'h1234_5678, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_CTX_SGN, 8'd255, 64'h5, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_CTX_BOOL, 8'd254, 64'h1, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_OPEN, 8'd0, 64'h0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    add_prim(bpe_pkg::FN_CLOSE, 8'd14, 64'h0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    for (r = 0; r < RANDOM_ITEMS; r++) stim_q.push_back(rand_prim());
    n_items = stim_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (sent_cnt < n_items) @(posedge clk);
    while (octet_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
